>>> src/rhro_pkg.sv
// Package for the row hue rainbow overlay: widths, mix constants, stage payload types.
// Used by every module of the block; depends on nothing.
package rhro_pkg;

   // field and register widths
   localparam int MAX_ROWS     = 4096;
   localparam int ROWS_BITS    = 13;
   localparam int ROW_BITS     = 12;
   localparam int CHANNEL_BITS = 16;
   localparam int WHEEL_BITS   = 8;

   // hue quotient: 3 segment bits over a Q16 offset
   localparam int FRAC_BITS    = 16;
   localparam int QUOT_BITS    = 19;
   localparam int REM_BITS     = 12;
   localparam int MULT6_BITS   = 15;
   localparam int DIV_STAGES   = QUOT_BITS;

   // Q16 blend weights, 0.3 wheel and 0.7 source
   localparam int MIX_W_BITS   = 15;
   localparam int MIX_S_BITS   = 16;
   localparam logic [MIX_W_BITS-1:0] WHEEL_MIX  = 15'd19661;
   localparam logic [MIX_S_BITS-1:0] SOURCE_MIX = 16'd45875;
   localparam int PROD_W_BITS  = WHEEL_BITS + MIX_W_BITS;
   localparam int PROD_S_BITS  = CHANNEL_BITS + MIX_S_BITS;

   localparam logic [WHEEL_BITS-1:0] WHEEL_FULL = 8'd255;
   localparam logic [WHEEL_BITS-1:0] WHEEL_NONE = 8'd0;

   // colour wheel segments
   typedef enum logic [2:0] {
      SEG_GREEN_UP  = 3'd0,
      SEG_RED_DOWN  = 3'd1,
      SEG_BLUE_UP   = 3'd2,
      SEG_GREEN_DN  = 3'd3,
      SEG_RED_UP    = 3'd4,
      SEG_BLUE_DN   = 3'd5
   } seg_type;

   // source pixel carried down the pipe
   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } pix_type;

   // divider slot: partial remainder, dividend tail shifting into quotient
   typedef struct packed {
      logic [REM_BITS-1:0]  rem;
      logic [QUOT_BITS-1:0] qt;
      pix_type              pix;
   } div_slot_type;

   // wheel colour and source pixel
   typedef struct packed {
      logic [WHEEL_BITS-1:0] wr;
      logic [WHEEL_BITS-1:0] wg;
      logic [WHEEL_BITS-1:0] wb;
      pix_type               pix;
   } wheel_slot_type;

endpackage

>>> src/rhro_prep.sv
// Input stage: clamps the row to the row count and forms the divider's start slot.
// Depends on rhro_pkg.
module rhro_prep (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [rhro_pkg::ROWS_BITS-1:0]     rows,
   input  logic                               in_valid,
   input  logic [rhro_pkg::ROW_BITS-1:0]      row_index,
   input  rhro_pkg::pix_type                  pix,
   output logic                               out_valid,
   output rhro_pkg::div_slot_type             out_slot
);

   logic                               valid_ff;
   rhro_pkg::div_slot_type             slot_ff;
   rhro_pkg::div_slot_type             slot_in;
   logic [rhro_pkg::ROWS_BITS-1:0]     rows_m1;
   logic [rhro_pkg::ROW_BITS-1:0]      row_eff;
   logic [rhro_pkg::MULT6_BITS-1:0]    row_x6;

   // clamp row below the count, times six by shift and add
   always_comb begin
      rows_m1 = rows - 13'd1;
      if ({1'b0, row_index} >= rows) begin
         row_eff = rows_m1[rhro_pkg::ROW_BITS-1:0];
      end else begin
         row_eff = row_index;
      end
      row_x6 = {1'b0, row_eff, 2'b00} + {2'b00, row_eff, 1'b0};
      // dividend is row_x6 << 16; top bits form the first remainder
      slot_in.rem = row_x6[rhro_pkg::MULT6_BITS-1:3];
      slot_in.qt  = {row_x6[2:0], {rhro_pkg::FRAC_BITS{1'b0}}};
      slot_in.pix = pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff <= slot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_slot  = slot_ff;

endmodule

>>> src/rhro_div_stage.sv
// One restoring division step: brings down one dividend bit, yields one quotient bit.
// Depends on rhro_pkg.
module rhro_div_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [rhro_pkg::ROWS_BITS-1:0]  rows,
   input  logic                            in_valid,
   input  rhro_pkg::div_slot_type          in_slot,
   output logic                            out_valid,
   output rhro_pkg::div_slot_type          out_slot
);

   logic                            valid_ff;
   rhro_pkg::div_slot_type          slot_ff;
   rhro_pkg::div_slot_type          slot_in;
   logic [rhro_pkg::ROWS_BITS-1:0]  trial;
   logic [rhro_pkg::ROWS_BITS-1:0]  diff;
   logic                            fits;

   // compare and subtract; remainder stays below the row count
   always_comb begin
      trial = {in_slot.rem, in_slot.qt[rhro_pkg::QUOT_BITS-1]};
      diff  = trial - rows;
      fits  = (trial >= rows);
      slot_in.rem = fits ? diff[rhro_pkg::REM_BITS-1:0] : trial[rhro_pkg::REM_BITS-1:0];
      slot_in.qt  = {in_slot.qt[rhro_pkg::QUOT_BITS-2:0], fits};
      slot_in.pix = in_slot.pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff <= slot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_slot  = slot_ff;

endmodule

>>> src/rhro_wheel.sv
// Colour wheel stage: segment select and 8-bit ramp from the Q16 hue.
// Depends on rhro_pkg.
module rhro_wheel (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               in_valid,
   input  rhro_pkg::div_slot_type             in_slot,
   output logic                               out_valid,
   output rhro_pkg::wheel_slot_type           out_slot
);

   logic                              valid_ff;
   rhro_pkg::wheel_slot_type          slot_ff;
   rhro_pkg::wheel_slot_type          slot_in;
   rhro_pkg::seg_type                 seg;
   logic [rhro_pkg::FRAC_BITS-1:0]    off;
   logic [rhro_pkg::FRAC_BITS:0]      rest;
   logic [24:0]                       up_prod;
   logic [24:0]                       down_prod;
   logic [rhro_pkg::WHEEL_BITS-1:0]   up;
   logic [rhro_pkg::WHEEL_BITS-1:0]   down;

   // ramps: x*255 as (x<<8)-x, keep bits above the Q16 point
   always_comb begin
      seg       = rhro_pkg::seg_type'(in_slot.qt[rhro_pkg::QUOT_BITS-1:rhro_pkg::FRAC_BITS]);
      off       = in_slot.qt[rhro_pkg::FRAC_BITS-1:0];
      rest      = 17'h10000 - {1'b0, off};
      up_prod   = {1'b0, off, 8'd0} - {9'd0, off};
      down_prod = {rest, 8'd0} - {8'd0, rest};
      up        = up_prod[23:16];
      down      = down_prod[23:16];
   end

   // segment select
   always_comb begin
      slot_in.pix = in_slot.pix;
      case (seg)
         rhro_pkg::SEG_GREEN_UP: begin
            slot_in.wr = rhro_pkg::WHEEL_FULL;
            slot_in.wg = up;
            slot_in.wb = rhro_pkg::WHEEL_NONE;
         end
         rhro_pkg::SEG_RED_DOWN: begin
            slot_in.wr = down;
            slot_in.wg = rhro_pkg::WHEEL_FULL;
            slot_in.wb = rhro_pkg::WHEEL_NONE;
         end
         rhro_pkg::SEG_BLUE_UP: begin
            slot_in.wr = rhro_pkg::WHEEL_NONE;
            slot_in.wg = rhro_pkg::WHEEL_FULL;
            slot_in.wb = up;
         end
         rhro_pkg::SEG_GREEN_DN: begin
            slot_in.wr = rhro_pkg::WHEEL_NONE;
            slot_in.wg = down;
            slot_in.wb = rhro_pkg::WHEEL_FULL;
         end
         rhro_pkg::SEG_RED_UP: begin
            slot_in.wr = up;
            slot_in.wg = rhro_pkg::WHEEL_NONE;
            slot_in.wb = rhro_pkg::WHEEL_FULL;
         end
         rhro_pkg::SEG_BLUE_DN: begin
            slot_in.wr = rhro_pkg::WHEEL_FULL;
            slot_in.wg = rhro_pkg::WHEEL_NONE;
            slot_in.wb = down;
         end
         default: begin
            slot_in.wr = rhro_pkg::WHEEL_NONE;
            slot_in.wg = rhro_pkg::WHEEL_NONE;
            slot_in.wb = rhro_pkg::WHEEL_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff <= slot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_slot  = slot_ff;

endmodule

>>> src/rhro_blend.sv
// Blend stages: registered products, then Q16 sum and truncation to the output register.
// Depends on rhro_pkg.
module rhro_blend (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  rhro_pkg::wheel_slot_type            in_slot,
   output logic                                out_valid,
   output rhro_pkg::pix_type                   out_pix
);

   logic                                  mul_valid_ff;
   logic [rhro_pkg::PROD_W_BITS-1:0]      wr_prod_ff, wg_prod_ff, wb_prod_ff;
   logic [rhro_pkg::PROD_S_BITS-1:0]      sr_prod_ff, sg_prod_ff, sb_prod_ff;
   logic [rhro_pkg::PROD_W_BITS-1:0]      wr_prod_in, wg_prod_in, wb_prod_in;
   logic [rhro_pkg::PROD_S_BITS-1:0]      sr_prod_in, sg_prod_in, sb_prod_in;
   logic                                  out_valid_ff;
   rhro_pkg::pix_type                     pix_ff;
   rhro_pkg::pix_type                     pix_in;
   logic [rhro_pkg::PROD_S_BITS-1:0]      sum_r, sum_g, sum_b;

   // weight products
   always_comb begin
      wr_prod_in = in_slot.wr * rhro_pkg::WHEEL_MIX;
      wg_prod_in = in_slot.wg * rhro_pkg::WHEEL_MIX;
      wb_prod_in = in_slot.wb * rhro_pkg::WHEEL_MIX;
      sr_prod_in = in_slot.pix.red   * rhro_pkg::SOURCE_MIX;
      sg_prod_in = in_slot.pix.green * rhro_pkg::SOURCE_MIX;
      sb_prod_in = in_slot.pix.blue  * rhro_pkg::SOURCE_MIX;
   end

   // sum stays below 2^32, so no carry out
   always_comb begin
      sum_r = sr_prod_ff + {{(rhro_pkg::PROD_S_BITS-rhro_pkg::PROD_W_BITS){1'b0}}, wr_prod_ff};
      sum_g = sg_prod_ff + {{(rhro_pkg::PROD_S_BITS-rhro_pkg::PROD_W_BITS){1'b0}}, wg_prod_ff};
      sum_b = sb_prod_ff + {{(rhro_pkg::PROD_S_BITS-rhro_pkg::PROD_W_BITS){1'b0}}, wb_prod_ff};
      pix_in.red   = sum_r[rhro_pkg::PROD_S_BITS-1:rhro_pkg::FRAC_BITS];
      pix_in.green = sum_g[rhro_pkg::PROD_S_BITS-1:rhro_pkg::FRAC_BITS];
      pix_in.blue  = sum_b[rhro_pkg::PROD_S_BITS-1:rhro_pkg::FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= in_valid;
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wr_prod_ff <= wr_prod_in;
         wg_prod_ff <= wg_prod_in;
         wb_prod_ff <= wb_prod_in;
         sr_prod_ff <= sr_prod_in;
         sg_prod_ff <= sg_prod_in;
         sb_prod_ff <= sb_prod_in;
         pix_ff     <= pix_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pix   = pix_ff;

endmodule

>>> src/row_hue_rainbow_overlay.sv
// Row hue rainbow overlay: a pipeline of an input stage, 19 restoring division stages,
// a wheel stage and two blend stages.
// Throughput one pixel per clock; the whole pipe holds while a result waits.
// Synchronous active-high reset empties the pipe and sets the row count to 1.
// Depends on rhro_pkg, rhro_prep, rhro_div_stage, rhro_wheel, rhro_blend.
module row_hue_rainbow_overlay (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [rhro_pkg::ROWS_BITS-1:0]        csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [rhro_pkg::ROW_BITS-1:0]         req_row_index,
   input  logic [rhro_pkg::CHANNEL_BITS-1:0]     req_red_in,
   input  logic [rhro_pkg::CHANNEL_BITS-1:0]     req_green_in,
   input  logic [rhro_pkg::CHANNEL_BITS-1:0]     req_blue_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rhro_pkg::CHANNEL_BITS-1:0]     rsp_red_out,
   output logic [rhro_pkg::CHANNEL_BITS-1:0]     rsp_green_out,
   output logic [rhro_pkg::CHANNEL_BITS-1:0]     rsp_blue_out
);

   logic [rhro_pkg::ROWS_BITS-1:0]   rows_ff;
   logic [rhro_pkg::ROWS_BITS-1:0]   rows_in;
   logic                             advance;
   rhro_pkg::pix_type                req_pix;
   logic                             div_valid [rhro_pkg::DIV_STAGES+1];
   rhro_pkg::div_slot_type           div_slot  [rhro_pkg::DIV_STAGES+1];
   logic                             wheel_valid;
   rhro_pkg::wheel_slot_type         wheel_slot;
   rhro_pkg::pix_type                rsp_pix;

   // row count register, held as the effective count 1..MAX_ROWS
   always_comb begin
      if (csr_write_data == '0) begin
         rows_in = 13'd1;
      end else if (csr_write_data > rhro_pkg::ROWS_BITS'(rhro_pkg::MAX_ROWS)) begin
         rows_in = rhro_pkg::ROWS_BITS'(rhro_pkg::MAX_ROWS);
      end else begin
         rows_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 13'd1;
      end else if (csr_write_enable) begin
         rows_ff <= rows_in;
      end
   end

   // whole pipe moves unless the output register holds an untaken result
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign req_pix.red   = req_red_in;
   assign req_pix.green = req_green_in;
   assign req_pix.blue  = req_blue_in;

   rhro_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .rows      (rows_ff),
      .in_valid  (req_valid),
      .row_index (req_row_index),
      .pix       (req_pix),
      .out_valid (div_valid[0]),
      .out_slot  (div_slot[0])
   );

   // one quotient bit per stage
   for (genvar i = 0; i < rhro_pkg::DIV_STAGES; i++) begin : g_div
      rhro_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .rows      (rows_ff),
         .in_valid  (div_valid[i]),
         .in_slot   (div_slot[i]),
         .out_valid (div_valid[i+1]),
         .out_slot  (div_slot[i+1])
      );
   end

   rhro_wheel u_wheel (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (div_valid[rhro_pkg::DIV_STAGES]),
      .in_slot   (div_slot[rhro_pkg::DIV_STAGES]),
      .out_valid (wheel_valid),
      .out_slot  (wheel_slot)
   );

   rhro_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (wheel_valid),
      .in_slot   (wheel_slot),
      .out_valid (rsp_valid),
      .out_pix   (rsp_pix)
   );

   assign rsp_red_out   = rsp_pix.red;
   assign rsp_green_out = rsp_pix.green;
   assign rsp_blue_out  = rsp_pix.blue;

endmodule
